FILE: rtl/core/mtmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtmq_pkg
// Types, constants and helpers shared by the message tag match queue.
// ----------------------------------------------------------------------------
package mtmq_pkg;

  localparam int MAX_RANKS   = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam int RANK_W      = $clog2(MAX_RANKS);
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = SLOT_W + 1;
  localparam int GSIZE_W     = 5;
  localparam int TAG_W       = 32;
  localparam int COUNT_W     = 31;
  localparam int NRES        = 3;

  localparam logic [TAG_W-1:0] TAG_GROUP_BEGIN = 32'hFFFF_FFFE;
  localparam logic [TAG_W-1:0] TAG_GROUP_END   = 32'hFFFF_FFFD;
  localparam logic [TAG_W-1:0] TAG_PEER_LEFT   = 32'hFFFF_FFF9;
  localparam logic [TAG_W-1:0] TAG_GROUP_FAIL  = 32'hFFFF_FFF8;
  localparam logic [TAG_W-1:0] TAG_ANY         = 32'h0000_0000;

  localparam logic CFG_OWN_RANK   = 1'b0;
  localparam logic CFG_GROUP_SIZE = 1'b1;

  typedef enum logic [2:0] {
    OUT_RECEIVED   = 3'd0,
    OUT_REMOTE_FIN = 3'd1,
    OUT_SELF_OP    = 3'd2,
    OUT_NO_RANK    = 3'd3,
    OUT_SEND_GFAIL = 3'd4,
    OUT_DROPPED    = 3'd5,
    OUT_BUSY       = 3'd6
  } outcome_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] dest;
  } res_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  order;
    logic [COUNT_W-1:0] count;
    logic [TAG_W-1:0]   tag;
    logic [RANK_W-1:0]  source;
  } entry_t;

  function automatic logic is_group_tag(input logic [TAG_W-1:0] t);
    return (t == TAG_GROUP_BEGIN) || (t == TAG_GROUP_END);
  endfunction

  function automatic logic tag_fits(input logic [TAG_W-1:0] want,
                                    input logic [TAG_W-1:0] have);
    logic positive;
    positive = (have != TAG_ANY) && !have[TAG_W-1];
    return ((want == TAG_ANY) && positive) || (want == have);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtmq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtmq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtmq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/message_tag_match_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// message_tag_match_queue
// Tag matching engine: stores arrivals, serves receive requests, tracks
// peer-left and group-fail notices.
// ----------------------------------------------------------------------------
// One item at a time. Rank checks, busy and notices are settled without a table
// search. An ordinary arrival searches the valid bits for the first free slot,
// one slot a cycle. A receive request scans the entry memory through its single
// read port; a match then renumbers the ages of the remaining entries in a
// second pass after its result is transferred. Valid bits live in flip-flops,
// so no clearing pass follows reset.
module message_tag_match_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic signed [31:0]            in_rank,
  input  wire logic signed [31:0]            in_msg_tag,
  input  wire logic [30:0]                   in_msg_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_outcome,
  output logic [mtmq_pkg::SLOT_W-1:0]        out_match_slot,
  output logic [mtmq_pkg::RANK_W-1:0]        out_dest_rank,
  output logic                               out_last_of_run,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [mtmq_pkg::GSIZE_W-1:0]  cfg_data
);
  import mtmq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLASS, ST_FREE, ST_SCAN, ST_RESOLVE, ST_EMIT, ST_SWEEP
  } state_t;

  state_t               state_r, state_nxt;
  logic                 req_r, req_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 self_r, self_nxt;
  logic                 oor_r, oor_nxt;
  logic [RANK_W-1:0]    own_r, own_nxt;
  logic [GSIZE_W-1:0]   gsize_r, gsize_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [RANK_W-1:0]    pend_src_r, pend_src_nxt;
  logic [TAG_W-1:0]     pend_tag_r, pend_tag_nxt;
  logic [COUNT_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [MAX_RANKS-1:0] left_r, left_nxt;
  logic                 gf_r, gf_nxt;
  logic [OCC_W-1:0]     cnt_r, cnt_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_W-1:0]    best_r, best_nxt;
  logic [SLOT_W-1:0]    best_age_r, best_age_nxt;
  res_t                 res_r [NRES];
  res_t                 res_nxt [NRES];
  logic [1:0]           nres_r, nres_nxt;
  logic [1:0]           ptr_r, ptr_nxt;
  logic                 sweep_r, sweep_nxt;

  logic [GSIZE_W-1:0]   used;
  logic [GSIZE_W-1:0]   child0, child1;
  logic [SLOT_W-1:0]    chk_idx;
  logic [SLOT_W-1:0]    cur_idx;
  logic                 scan_done;
  entry_t               rd_entry;
  entry_t               wr_entry;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic                 last;

  assign used      = (gsize_r > GSIZE_W'(MAX_RANKS)) ? GSIZE_W'(MAX_RANKS) : gsize_r;
  assign child0    = {own_r, 1'b1};
  assign child1    = child0 + 1'b1;
  assign cur_idx   = cnt_r[SLOT_W-1:0];
  assign chk_idx   = cnt_r[SLOT_W-1:0] - 1'b1;
  assign scan_done = (cnt_r == OCC_W'(QUEUE_DEPTH));
  assign last      = (ptr_r == nres_r - 2'd1);

  mtmq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (cur_idx),
    .rdata (rd_entry)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = (state_r == ST_EMIT);
  assign out_outcome     = res_r[ptr_r].outcome;
  assign out_match_slot  = res_r[ptr_r].slot;
  assign out_dest_rank   = res_r[ptr_r].dest;
  assign out_last_of_run = last;

  always_comb begin
    logic [1:0] n;
    logic       hit;
    n            = 2'd0;
    hit          = 1'b0;
    state_nxt    = state_r;
    req_nxt      = req_r;
    rank_nxt     = rank_r;
    tag_nxt      = tag_r;
    count_nxt    = count_r;
    self_nxt     = self_r;
    oor_nxt      = oor_r;
    own_nxt      = own_r;
    gsize_nxt    = gsize_r;
    valid_nxt    = valid_r;
    occ_nxt      = occ_r;
    pend_v_nxt   = pend_v_r;
    pend_src_nxt = pend_src_r;
    pend_tag_nxt = pend_tag_r;
    pend_cnt_nxt = pend_cnt_r;
    left_nxt     = left_r;
    gf_nxt       = gf_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    res_nxt      = res_r;
    nres_nxt     = nres_r;
    ptr_nxt      = ptr_r;
    sweep_nxt    = sweep_r;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx;
    wr_entry     = rd_entry;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_RANK:   own_nxt   = cfg_data[RANK_W-1:0];
        CFG_GROUP_SIZE: gsize_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          rank_nxt  = in_rank[RANK_W-1:0];
          tag_nxt   = in_msg_tag;
          count_nxt = in_msg_count;
          self_nxt  = ($unsigned(in_rank) == {{(32-RANK_W){1'b0}}, own_r});
          oor_nxt   = ($unsigned(in_rank) >= {{(32-GSIZE_W){1'b0}}, used});
          state_nxt = ST_CLASS;
        end
      end

      ST_CLASS: begin
        ptr_nxt   = 2'd0;
        sweep_nxt = 1'b0;
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_EMIT;
        if (self_r) begin
          res_nxt[n] = '{OUT_SELF_OP, '0, '0}; n = n + 2'd1;
        end else if (oor_r) begin
          res_nxt[n] = '{OUT_NO_RANK, '0, '0}; n = n + 2'd1;
        end else if (!req_r) begin
          if (tag_r == TAG_PEER_LEFT) begin
            left_nxt[rank_r] = 1'b1;
            if (pend_v_r && pend_src_r == rank_r) begin
              if (is_group_tag(pend_tag_r)) begin
                pend_v_nxt = 1'b0;
                res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
                if (own_r != '0) begin
                  res_nxt[n] = '{OUT_SEND_GFAIL, '0, '0}; n = n + 2'd1;
                end
              end else if (!pend_tag_r[TAG_W-1]) begin
                pend_v_nxt = 1'b0;
                res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
              end
            end
          end else if (tag_r == TAG_GROUP_FAIL) begin
            if (!gf_r) begin
              gf_nxt = 1'b1;
              if (pend_v_r && is_group_tag(pend_tag_r)) begin
                pend_v_nxt = 1'b0;
                res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
              end
              if (child0 < used) begin
                res_nxt[n] = '{OUT_SEND_GFAIL, '0, child0[RANK_W-1:0]}; n = n + 2'd1;
                if (child1 < used) begin
                  res_nxt[n] = '{OUT_SEND_GFAIL, '0, child1[RANK_W-1:0]}; n = n + 2'd1;
                end
              end
            end
          end else if (occ_r >= OCC_W'(QUEUE_DEPTH)) begin
            res_nxt[n] = '{OUT_DROPPED, '0, '0}; n = n + 2'd1;
          end else begin
            state_nxt = ST_FREE;
          end
        end else if (pend_v_r) begin
          res_nxt[n] = '{OUT_BUSY, '0, '0}; n = n + 2'd1;
        end else begin
          state_nxt = ST_SCAN;
        end
        nres_nxt = n;
        if (state_nxt == ST_EMIT && n == 2'd0) begin
          state_nxt = ST_IDLE;
        end
      end

      // walk the valid bits for the lowest free slot
      ST_FREE: begin
        ptr_nxt = 2'd0;
        if (scan_done) begin
          res_nxt[0] = '{OUT_DROPPED, '0, '0};
          nres_nxt   = 2'd1;
          state_nxt  = ST_EMIT;
        end else if (!valid_r[cur_idx]) begin
          if (pend_v_r && pend_src_r == rank_r && pend_cnt_r == count_r &&
              tag_fits(pend_tag_r, tag_r)) begin
            pend_v_nxt = 1'b0;
            res_nxt[0] = '{OUT_RECEIVED, cur_idx, '0};
            nres_nxt   = 2'd1;
            state_nxt  = ST_EMIT;
          end else begin
            ram_we             = 1'b1;
            ram_waddr          = cur_idx;
            wr_entry           = '{occ_r[SLOT_W-1:0], count_r, tag_r, rank_r};
            valid_nxt[cur_idx] = 1'b1;
            occ_nxt            = occ_r + 1'b1;
            state_nxt          = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // the compare works on the registered read of the previous address
      ST_SCAN: begin
        if (cnt_r != '0) begin
          hit = valid_r[chk_idx] && rd_entry.source == rank_r &&
                rd_entry.count == count_r && tag_fits(tag_r, rd_entry.tag) &&
                (!found_r || rd_entry.order < best_age_r);
          if (hit) begin
            found_nxt    = 1'b1;
            best_nxt     = chk_idx;
            best_age_nxt = rd_entry.order;
          end
        end
        if (scan_done) begin
          state_nxt = ST_RESOLVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_RESOLVE: begin
        cnt_nxt   = '0;
        state_nxt = ST_EMIT;
        if (found_r) begin
          res_nxt[n] = '{OUT_RECEIVED, best_r, '0}; n = n + 2'd1;
          valid_nxt[best_r] = 1'b0;
          occ_nxt   = occ_r - 1'b1;
          sweep_nxt = 1'b1;
        end else if (is_group_tag(tag_r)) begin
          if (left_r[rank_r]) begin
            res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
            if (own_r != '0) begin
              res_nxt[n] = '{OUT_SEND_GFAIL, '0, '0}; n = n + 2'd1;
            end
          end else if (gf_r) begin
            res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
          end
        end else if (!tag_r[TAG_W-1] && left_r[rank_r]) begin
          res_nxt[n] = '{OUT_REMOTE_FIN, '0, '0}; n = n + 2'd1;
        end
        nres_nxt = n;
        if (n == 2'd0) begin
          pend_v_nxt   = 1'b1;
          pend_src_nxt = rank_r;
          pend_tag_nxt = tag_r;
          pend_cnt_nxt = count_r;
          state_nxt    = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_ready) begin
          ptr_nxt = ptr_r + 2'd1;
          if (last) begin
            state_nxt = sweep_r ? ST_SWEEP : ST_IDLE;
          end
        end
      end

      // close the age gap left by the taken entry
      ST_SWEEP: begin
        if (cnt_r != '0 && valid_r[chk_idx] && rd_entry.order > best_age_r) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx;
          wr_entry.order = rd_entry.order - 1'b1;
        end
        if (scan_done) begin
          sweep_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      own_r      <= '0;
      gsize_r    <= GSIZE_W'(1);
      valid_r    <= '0;
      occ_r      <= '0;
      pend_v_r   <= 1'b0;
      pend_src_r <= '0;
      pend_tag_r <= '0;
      pend_cnt_r <= '0;
      left_r     <= '0;
      gf_r       <= 1'b0;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      nres_r     <= '0;
      ptr_r      <= '0;
      sweep_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      own_r      <= own_nxt;
      gsize_r    <= gsize_nxt;
      valid_r    <= valid_nxt;
      occ_r      <= occ_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_src_r <= pend_src_nxt;
      pend_tag_r <= pend_tag_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      left_r     <= left_nxt;
      gf_r       <= gf_nxt;
      cnt_r      <= cnt_nxt;
      found_r    <= found_nxt;
      nres_r     <= nres_nxt;
      ptr_r      <= ptr_nxt;
      sweep_r    <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rank_r     <= rank_nxt;
    tag_r      <= tag_nxt;
    count_r    <= count_nxt;
    self_r     <= self_nxt;
    oor_r      <= oor_nxt;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
    res_r      <= res_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is shown");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above table depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_FREE || state_r == ST_SWEEP))
    else $error("entry memory written outside store or sweep");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FREE && state_nxt == ST_IDLE) |=> ($countones(valid_r) == occ_r))
    else $error("valid bits and occupancy disagree");

endmodule
`default_nettype wire
